/* hdl/tkf_pkg.sv */
// package: shared types, constants and the cordic angle table for the tilt kalman filter
package tkf_pkg;

  localparam int CORDIC_STEPS_DEF = 16;
  localparam int FRAC_BITS_DEF    = 16;
  localparam int ANG_UNIT_BITS    = 24;
  localparam int COV_MAX          = 131071;
  localparam int ONE_Q16          = 65536;

  localparam logic [2:0] REG_PROCESS_NOISE  = 3'd0;
  localparam logic [2:0] REG_MEASURE_NOISE  = 3'd1;
  localparam logic [2:0] REG_TILT_RATE_GAIN = 3'd2;
  localparam logic [2:0] REG_YAW_RATE_GAIN  = 3'd3;
  localparam logic [2:0] REG_YAW_RATE_BIAS  = 3'd4;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CORDIC_INIT,
    ST_CORDIC_STEP,
    ST_ANGLE,
    ST_PREDICT,
    ST_DIV_INIT,
    ST_DIV_STEP,
    ST_UPDATE_MUL,
    ST_UPDATE,
    ST_NEXT_AXIS,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic load;
    logic axis;
    logic cordic_init;
    logic cordic_step;
    logic angle;
    logic predict;
    logic div_init;
    logic div_step;
    logic update_mul;
    logic update;
    logic output_load;
  } cmd_t;

  typedef struct packed {
    logic cordic_done;
    logic div_done;
  } status_t;

  function automatic logic [29:0] atan_entry(input logic [4:0] i);
    logic [29:0] v;
    case (i)
      5'd0:  v = 30'd754974720;
      5'd1:  v = 30'd445687602;
      5'd2:  v = 30'd235489088;
      5'd3:  v = 30'd119537938;
      5'd4:  v = 30'd60000934;
      5'd5:  v = 30'd30029717;
      5'd6:  v = 30'd15018523;
      5'd7:  v = 30'd7509720;
      5'd8:  v = 30'd3754917;
      5'd9:  v = 30'd1877466;
      5'd10: v = 30'd938734;
      5'd11: v = 30'd469367;
      5'd12: v = 30'd234684;
      5'd13: v = 30'd117342;
      5'd14: v = 30'd58671;
      5'd15: v = 30'd29335;
      5'd16: v = 30'd14668;
      5'd17: v = 30'd7334;
      5'd18: v = 30'd3667;
      5'd19: v = 30'd1833;
      5'd20: v = 30'd917;
      5'd21: v = 30'd458;
      5'd22: v = 30'd229;
      5'd23: v = 30'd115;
      default: v = 30'd0;
    endcase
    return v;
  endfunction

endpackage

/* hdl/tkf_ctrl.sv */
// controller: sequences cordic, prediction, gain division and update for each axis
module tkf_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  output logic             out_valid,
  input  logic             out_ready,
  input  tkf_pkg::status_t status,
  output tkf_pkg::cmd_t    cmd
);

  tkf_pkg::state_t state, state_next;
  logic axis, axis_next;
  logic out_full, out_full_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= tkf_pkg::ST_IDLE;
      axis     <= 1'b0;
      out_full <= 1'b0;
    end else begin
      state    <= state_next;
      axis     <= axis_next;
      out_full <= out_full_next;
    end
  end

  always_comb begin
    state_next = state;
    axis_next  = axis;
    case (state)
      tkf_pkg::ST_IDLE: if (in_valid) begin
        state_next = tkf_pkg::ST_CORDIC_INIT;
        axis_next  = 1'b0;
      end
      tkf_pkg::ST_CORDIC_INIT: state_next = tkf_pkg::ST_CORDIC_STEP;
      tkf_pkg::ST_CORDIC_STEP: if (status.cordic_done) state_next = tkf_pkg::ST_ANGLE;
      tkf_pkg::ST_ANGLE:       state_next = tkf_pkg::ST_PREDICT;
      tkf_pkg::ST_PREDICT:     state_next = tkf_pkg::ST_DIV_INIT;
      tkf_pkg::ST_DIV_INIT:    state_next = tkf_pkg::ST_DIV_STEP;
      tkf_pkg::ST_DIV_STEP:    if (status.div_done) state_next = tkf_pkg::ST_UPDATE_MUL;
      tkf_pkg::ST_UPDATE_MUL:  state_next = tkf_pkg::ST_UPDATE;
      tkf_pkg::ST_UPDATE:      state_next = tkf_pkg::ST_NEXT_AXIS;
      tkf_pkg::ST_NEXT_AXIS: begin
        if (axis) begin
          state_next = tkf_pkg::ST_OUT;
        end else begin
          axis_next  = 1'b1;
          state_next = tkf_pkg::ST_CORDIC_INIT;
        end
      end
      tkf_pkg::ST_OUT: if (!out_full || out_ready) state_next = tkf_pkg::ST_IDLE;
      default: state_next = tkf_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    out_full_next = out_full;
    if (out_full && out_ready) out_full_next = 1'b0;
    if (state == tkf_pkg::ST_OUT && (!out_full || out_ready)) out_full_next = 1'b1;
  end

  always_comb begin
    cmd             = '0;
    cmd.axis        = axis;
    cmd.load        = (state == tkf_pkg::ST_IDLE) && in_valid;
    cmd.cordic_init = (state == tkf_pkg::ST_CORDIC_INIT);
    cmd.cordic_step = (state == tkf_pkg::ST_CORDIC_STEP);
    cmd.angle       = (state == tkf_pkg::ST_ANGLE);
    cmd.predict     = (state == tkf_pkg::ST_PREDICT);
    cmd.div_init    = (state == tkf_pkg::ST_DIV_INIT);
    cmd.div_step    = (state == tkf_pkg::ST_DIV_STEP);
    cmd.update_mul  = (state == tkf_pkg::ST_UPDATE_MUL);
    cmd.update      = (state == tkf_pkg::ST_UPDATE);
    cmd.output_load = (state == tkf_pkg::ST_OUT) && (!out_full || out_ready);
  end

  assign in_ready  = (state == tkf_pkg::ST_IDLE);
  assign out_valid = out_full;

endmodule

/* hdl/tkf_datapath.sv */
// datapath: cordic vectoring unit, kalman arithmetic, divider, yaw integrator and output registers
module tkf_datapath #(
  parameter int CORDIC_STEPS = tkf_pkg::CORDIC_STEPS_DEF,
  parameter int FRAC_BITS    = tkf_pkg::FRAC_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  tkf_pkg::cmd_t       cmd,
  output tkf_pkg::status_t    status,
  input  logic                cfg_write,
  input  logic [2:0]          cfg_index,
  input  logic [15:0]         cfg_data,
  input  logic signed [15:0]  accel_x,
  input  logic signed [15:0]  accel_y,
  input  logic signed [15:0]  accel_z,
  input  logic signed [15:0]  gyro_x,
  input  logic signed [15:0]  gyro_y,
  input  logic signed [15:0]  gyro_z,
  output logic signed [24:0]  roll_estimate,
  output logic signed [24:0]  pitch_estimate,
  output logic signed [31:0]  yaw_angle,
  output logic signed [24:0]  accel_roll,
  output logic signed [24:0]  accel_pitch
);

  localparam int SH     = tkf_pkg::ANG_UNIT_BITS - FRAC_BITS;
  localparam int CNT_W  = $clog2(CORDIC_STEPS + 1);
  localparam logic signed [63:0] LIM    = 64'sd180 <<< FRAC_BITS;
  localparam logic signed [63:0] HALF_T = 64'sd180 <<< tkf_pkg::ANG_UNIT_BITS;
  localparam logic signed [63:0] RND    = (SH > 0) ? (64'sd1 <<< (SH - 1)) : 64'sd0;
  localparam logic signed [63:0] S32_HI = 64'sd2147483647;
  localparam logic signed [63:0] S32_LO = -64'sd2147483648;

  // configuration
  logic [15:0]        process_noise, measure_noise, tilt_rate_gain, yaw_rate_gain;
  logic signed [15:0] yaw_rate_bias;

  always_ff @(posedge clk) begin
    if (rst) begin
      process_noise  <= 16'd164;
      measure_noise  <= 16'd19661;
      tilt_rate_gain <= 16'd5120;
      yaw_rate_gain  <= 16'd5120;
      yaw_rate_bias  <= 16'sd0;
    end else if (cfg_write) begin
      case (cfg_index)
        tkf_pkg::REG_PROCESS_NOISE:  process_noise  <= cfg_data;
        tkf_pkg::REG_MEASURE_NOISE:  measure_noise  <= cfg_data;
        tkf_pkg::REG_TILT_RATE_GAIN: tilt_rate_gain <= cfg_data;
        tkf_pkg::REG_YAW_RATE_GAIN:  yaw_rate_gain  <= cfg_data;
        tkf_pkg::REG_YAW_RATE_BIAS:  yaw_rate_bias  <= $signed(cfg_data);
        default: ;
      endcase
    end
  end

  // sample registers
  logic signed [15:0] ax, ay, az, gx, gy, gz;
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      ax <= accel_x; ay <= accel_y; az <= accel_z;
      gx <= gyro_x;  gy <= gyro_y;  gz <= gyro_z;
    end
  end

  // cordic
  logic signed [35:0] cx, cy;
  logic signed [33:0] cz;
  logic [CNT_W-1:0]   cnt;
  logic               czero;
  logic signed [15:0] yin;
  logic signed [35:0] xs, ys, zt;

  assign yin = cmd.axis ? ax : ay;
  assign xs  = cx >>> cnt;
  assign ys  = cy >>> cnt;
  assign zt  = 36'(tkf_pkg::atan_entry(5'(cnt)));
  assign status.cordic_done = (cnt == CNT_W'(CORDIC_STEPS - 1));

  always_ff @(posedge clk) begin
    if (cmd.cordic_init) begin
      cnt   <= '0;
      czero <= (az == 16'sd0) && (yin == 16'sd0);
      if (az < 0) begin
        cx <= -($signed({{20{az[15]}}, az}) <<< 16);
        cy <= -($signed({{20{yin[15]}}, yin}) <<< 16);
        cz <= (yin >= 0) ? 34'(HALF_T) : -34'(HALF_T);
      end else begin
        cx <= $signed({{20{az[15]}}, az}) <<< 16;
        cy <= $signed({{20{yin[15]}}, yin}) <<< 16;
        cz <= '0;
      end
    end else if (cmd.cordic_step) begin
      cnt <= cnt + 1'b1;
      if (cy >= 0) begin
        cx <= cx + ys; cy <= cy - xs; cz <= cz + 34'(zt);
      end else begin
        cx <= cx - ys; cy <= cy + xs; cz <= cz - 34'(zt);
      end
    end
  end

  // angle rounding and clamp
  logic signed [63:0] zr;
  logic signed [31:0] meas;
  always_comb begin
    zr = (64'(cz) + RND) >>> SH;
    if (zr > LIM) zr = LIM;
    if (zr < -LIM) zr = -LIM;
    if (czero) zr = '0;
  end

  // filter state
  logic signed [31:0] roll_state, pitch_state, yaw_acc;
  logic [16:0]        roll_cov, pitch_cov;
  logic signed [31:0] xp;
  logic [16:0]        pp;
  logic signed [24:0] acc_r, acc_p;

  logic signed [15:0] rate;
  logic signed [32:0] prod;
  logic signed [63:0] xps;
  logic [17:0]        ppsum;

  assign rate = cmd.axis ? gy : gx;
  assign prod = rate * $signed({1'b0, tilt_rate_gain});
  always_comb begin
    xps = 64'(cmd.axis ? pitch_state : roll_state) + ((64'(prod) + RND) >>> SH);
    if (xps > S32_HI) xps = S32_HI;
    if (xps < S32_LO) xps = S32_LO;
    ppsum = 18'(cmd.axis ? pitch_cov : roll_cov) + 18'(process_noise);
  end

  // restoring divider: k = floor(pp * 65536 / (pp + r))
  logic [17:0] den;
  logic [17:0] rem;
  logic [33:0] num;
  logic [16:0] kq;
  logic [5:0]  dcnt;
  logic [18:0] trial;
  assign trial = {rem, num[33]} - {1'b0, den};
  assign status.div_done = (dcnt == 6'd33);

  always_ff @(posedge clk) begin
    if (cmd.div_init) begin
      den  <= 18'(pp) + 18'(measure_noise);
      num  <= {1'b0, pp, 16'd0};
      rem  <= '0;
      kq   <= '0;
      dcnt <= '0;
    end else if (cmd.div_step) begin
      dcnt <= dcnt + 1'b1;
      num  <= num << 1;
      if (!trial[18]) begin
        rem <= trial[17:0];
        kq  <= {kq[15:0], 1'b1};
      end else begin
        rem <= {rem[16:0], num[33]};
        kq  <= {kq[15:0], 1'b0};
      end
    end
  end

  logic [16:0] k;
  assign k = (den == 18'd0) ? 17'(tkf_pkg::ONE_Q16) : kq;

  // update products
  logic signed [33:0] innov;
  logic signed [51:0] kinn;
  logic [33:0]        pnew;
  always_ff @(posedge clk) begin
    if (cmd.update_mul) begin
      innov <= 34'(meas) - 34'(xp);
      pnew  <= (34'(17'(tkf_pkg::ONE_Q16) - k) * 34'(pp)) >> 16;
    end
  end
  assign kinn = $signed({1'b0, k}) * innov;

  logic signed [63:0] xn;
  always_comb begin
    xn = 64'(xp) + ((64'(kinn) + 64'sd32768) >>> 16);
    if (xn > S32_HI) xn = S32_HI;
    if (xn < S32_LO) xn = S32_LO;
  end

  // yaw
  logic signed [16:0] gzb;
  logic signed [33:0] yprod;
  logic signed [63:0] ysum;
  assign gzb   = 17'(gz) - 17'(yaw_rate_bias);
  assign yprod = gzb * $signed({1'b0, yaw_rate_gain});
  always_comb begin
    ysum = 64'(yaw_acc) + ((64'(yprod) + RND) >>> SH);
    if (ysum > S32_HI) ysum = S32_HI;
    if (ysum < S32_LO) ysum = S32_LO;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      roll_state  <= '0;
      pitch_state <= '0;
      roll_cov    <= 17'(tkf_pkg::ONE_Q16);
      pitch_cov   <= 17'(tkf_pkg::ONE_Q16);
      yaw_acc     <= '0;
    end else begin
      if (cmd.update) begin
        if (cmd.axis) begin
          pitch_state <= 32'(xn);
          pitch_cov   <= 17'(pnew);
        end else begin
          roll_state  <= 32'(xn);
          roll_cov    <= 17'(pnew);
          yaw_acc     <= 32'(ysum);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.angle) begin
      meas <= 32'(zr);
      if (cmd.axis) acc_p <= 25'(zr);
      else          acc_r <= 25'(zr);
    end
    if (cmd.predict) begin
      xp <= 32'(xps);
      pp <= (ppsum > 18'(tkf_pkg::COV_MAX)) ? 17'(tkf_pkg::COV_MAX) : 17'(ppsum);
    end
  end

  function automatic logic signed [24:0] sat25(input logic signed [31:0] v);
    if (v > 32'sd16777215) return 25'sd16777215;
    if (v < -32'sd16777216) return -25'sd16777216;
    return 25'(v);
  endfunction

  always_ff @(posedge clk) begin
    if (cmd.output_load) begin
      roll_estimate  <= sat25(roll_state);
      pitch_estimate <= sat25(pitch_state);
      yaw_angle      <= yaw_acc;
      accel_roll     <= acc_r;
      accel_pitch    <= acc_p;
    end
  end

endmodule

/* hdl/tilt_kalman_filter_unit.sv */
// top level: tilt kalman filter unit joining controller and datapath
//
// one six-axis sample request enters on in_valid/in_ready; one result request
// leaves on out_valid/out_ready with filtered roll and pitch, integrated yaw
// and the raw accelerometer angles, all signed degrees with FRAC_BITS fraction
// bits. samples are handled one at a time: each axis runs CORDIC_STEPS cordic
// iterations and a 34-step restoring divide for the kalman gain, and a new
// sample is accepted only after both axes are done and the result is loaded
// into the output register, which raises out_valid. the result sits there;
// a new sample is taken while it waits, and the next result waits until the
// receiver takes the previous one. reset (synchronous, active high) restores
// register defaults, zero angles and unit covariance. registers are to be
// written by the user through cfg_write/cfg_index/cfg_data only while the
// unit is idle; the unit itself does not enforce this.
module tilt_kalman_filter_unit #(
  parameter int CORDIC_STEPS = tkf_pkg::CORDIC_STEPS_DEF,
  parameter int FRAC_BITS    = tkf_pkg::FRAC_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_write,
  input  logic [2:0]         cfg_index,
  input  logic [15:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [15:0] accel_x,
  input  logic signed [15:0] accel_y,
  input  logic signed [15:0] accel_z,
  input  logic signed [15:0] gyro_x,
  input  logic signed [15:0] gyro_y,
  input  logic signed [15:0] gyro_z,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [24:0] roll_estimate,
  output logic signed [24:0] pitch_estimate,
  output logic signed [31:0] yaw_angle,
  output logic signed [24:0] accel_roll,
  output logic signed [24:0] accel_pitch
);

  tkf_pkg::cmd_t    cmd;
  tkf_pkg::status_t status;

  tkf_ctrl u_ctrl (
    .clk, .rst, .in_valid, .in_ready, .out_valid, .out_ready, .status, .cmd
  );

  tkf_datapath #(.CORDIC_STEPS(CORDIC_STEPS), .FRAC_BITS(FRAC_BITS)) u_dp (
    .clk, .rst, .cmd, .status, .cfg_write, .cfg_index, .cfg_data,
    .accel_x, .accel_y, .accel_z, .gyro_x, .gyro_y, .gyro_z,
    .roll_estimate, .pitch_estimate, .yaw_angle, .accel_roll, .accel_pitch
  );

endmodule
